>>> rtl/core/kccb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kccb_pkg
// Command codes, address map constants and read source codes for the
// dictionary card core.
// ----------------------------------------------------------------------------
package kccb_pkg;

    localparam logic [2:0] CMD_HOST_RD = 3'd0;
    localparam logic [2:0] CMD_HOST_WR = 3'd1;
    localparam logic [2:0] CMD_SUB_RD  = 3'd2;
    localparam logic [2:0] CMD_SUB_WR  = 3'd3;
    localparam logic [2:0] CMD_HALT    = 3'd4;
    localparam logic [2:0] CMD_PROG_LD = 3'd5;
    localparam logic [2:0] CMD_DICT_LD = 3'd6;

    localparam logic [1:0] PORT_STATUS = 2'd0;
    localparam logic [1:0] PORT_WINDOW = 2'd1;
    localparam logic [1:0] PORT_HALT   = 2'd2;
    localparam logic [1:0] PORT_DATA   = 2'd3;

    localparam int RAM_DEPTH  = 8192;
    localparam int PROG_DEPTH = 16384;
    localparam int DICT_DEPTH = 393216;

    localparam logic [18:0] SUB_RAM_LO   = 19'h08000;
    localparam logic [18:0] SUB_BANK_REG = 19'h09fff;
    localparam logic [18:0] SUB_DICT_HI  = 19'h0b000;
    localparam logic [18:0] SUB_HOLE_HI  = 19'h0c000;
    localparam logic [18:0] SUB_TOP      = 19'h10000;
    localparam logic [18:0] PROG_LIMIT   = 19'h04000;
    localparam logic [18:0] DICT_LIMIT   = 19'h60000;
    localparam logic [18:0] CLR_LAST     = 19'h5ffff;
    localparam logic [18:0] PATCH_OFFSET = 19'h0000d;
    localparam logic [7:0]  PATCH_FROM   = 8'h8f;
    localparam logic [7:0]  PATCH_TO     = 8'h88;
    localparam logic [4:0]  WINDOW_PAGE  = 5'h1f;
    localparam logic [7:0]  HALTED_CODE  = 8'h7f;
    localparam logic [7:0]  IDLE_BYTE    = 8'hff;

    // where the returned byte comes from
    localparam logic [2:0] RSEL_FF     = 3'd0;
    localparam logic [2:0] RSEL_STATUS = 3'd1;
    localparam logic [2:0] RSEL_RAM    = 3'd2;
    localparam logic [2:0] RSEL_DICT   = 3'd3;
    localparam logic [2:0] RSEL_PROG   = 3'd4;
    localparam logic [2:0] RSEL_BANK   = 3'd5;

endpackage

>>> rtl/core/kanji_comm_card_bus_device_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanji_comm_card_bus_device_core
// Dictionary card core: host i/o ports and sub-cpu memory map over a shared
// ram, a program rom and a dictionary rom held in synchronous memories.
// ----------------------------------------------------------------------------
// done: the result strobe rises in the cycle after the beat is taken,
// together with the registered read of the memories
// throughput: one beat per cycle while busy is low, one access per memory per beat
// reset: a clearing pass over 393216 addresses fills the memories (ram 0x00,
// roms 0xff) with busy high; results cannot be stalled by the receiver
module kanji_comm_card_bus_device_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [18:0] address,
    input  logic [7:0]  data,
    input  logic        bus_halted,
    output logic        done,
    output logic [7:0]  read_data,
    output logic        halt_req_change,
    output logic        halt_req_level
);

    import kccb_pkg::*;

    logic        clearing_reg;
    logic [18:0] clr_reg;
    logic [5:0]  bank_reg, bank_next;
    logic [7:0]  pointer_reg, pointer_next;
    logic [15:0] glyph_reg, glyph_next;
    logic        halted_reg, halted_next;
    logic        done_reg;
    logic [2:0]  sel_reg, sel_next;
    logic        chg_reg, chg_next;
    logic        lvl_reg, lvl_next;

    logic        accept;
    logic        ram_we, prog_we, dict_we;
    logic [12:0] ram_addr;
    logic [13:0] prog_addr;
    logic [18:0] dict_addr;
    logic [7:0]  ram_wdata, prog_wdata, dict_wdata;
    logic [7:0]  ram_q, prog_q, dict_q;

    assign busy   = clearing_reg;
    assign accept = start && !clearing_reg;

    always_comb
    begin
        bank_next    = bank_reg;
        pointer_next = pointer_reg;
        glyph_next   = glyph_reg;
        halted_next  = halted_reg;
        sel_next     = RSEL_FF;
        chg_next     = 1'b0;
        lvl_next     = 1'b0;
        ram_we       = 1'b0;
        prog_we      = 1'b0;
        dict_we      = 1'b0;
        ram_addr     = address[12:0];
        prog_addr    = address[13:0];
        dict_addr    = address;
        ram_wdata    = data;
        prog_wdata   = data;
        dict_wdata   = data;

        if (clearing_reg)
        begin
            ram_we     = 1'b1;
            prog_we    = 1'b1;
            dict_we    = 1'b1;
            ram_addr   = clr_reg[12:0];
            prog_addr  = clr_reg[13:0];
            dict_addr  = clr_reg;
            ram_wdata  = 8'h00;
            prog_wdata = IDLE_BYTE;
            dict_wdata = IDLE_BYTE;
        end
        else if (accept)
        begin
            case (command)
                CMD_HOST_RD:
                begin
                    case (address[1:0])
                        PORT_STATUS:
                        begin
                            sel_next = halted_reg ? RSEL_STATUS : RSEL_FF;
                        end
                        PORT_WINDOW:
                        begin
                            ram_addr = {WINDOW_PAGE, pointer_reg};
                            if (halted_reg)
                            begin
                                sel_next     = RSEL_RAM;
                                pointer_next = pointer_reg + 8'd1;
                            end
                        end
                        default:
                        begin
                            // glyph bytes live in the upper part of the dictionary
                            dict_addr = {2'b10, glyph_reg, address[0]};
                            sel_next  = RSEL_DICT;
                        end
                    endcase
                end
                CMD_HOST_WR:
                begin
                    case (address[1:0])
                        PORT_STATUS:
                        begin
                            glyph_next = {data, glyph_reg[7:0]};
                        end
                        PORT_WINDOW:
                        begin
                            glyph_next = {glyph_reg[15:8], data};
                        end
                        PORT_HALT:
                        begin
                            chg_next = 1'b1;
                            lvl_next = !data[7];
                            if (!data[7])
                            begin
                                pointer_next = 8'd0;
                            end
                        end
                        default:
                        begin
                            ram_addr = {WINDOW_PAGE, pointer_reg};
                            if (halted_reg)
                            begin
                                ram_we       = 1'b1;
                                pointer_next = pointer_reg + 8'd1;
                            end
                        end
                    endcase
                end
                CMD_SUB_RD:
                begin
                    dict_addr = {1'b0, bank_reg, address[11:0]};
                    if (address < SUB_RAM_LO)
                    begin
                        sel_next = RSEL_FF;
                    end
                    else if (address < SUB_BANK_REG)
                    begin
                        sel_next = RSEL_RAM;
                    end
                    else if (address == SUB_BANK_REG)
                    begin
                        sel_next = RSEL_BANK;
                    end
                    else if (address < SUB_DICT_HI)
                    begin
                        sel_next = RSEL_DICT;
                    end
                    else if (address < SUB_HOLE_HI)
                    begin
                        sel_next = RSEL_FF;
                    end
                    else if (address < SUB_TOP)
                    begin
                        sel_next = RSEL_PROG;
                    end
                    else
                    begin
                        sel_next = RSEL_FF;
                    end
                end
                CMD_SUB_WR:
                begin
                    if (address == SUB_BANK_REG)
                    begin
                        chg_next  = 1'b1;
                        lvl_next  = !data[7];
                        bank_next = data[5:0];
                    end
                    else if (address >= SUB_RAM_LO && address < SUB_BANK_REG)
                    begin
                        ram_we = 1'b1;
                    end
                end
                CMD_HALT:
                begin
                    halted_next = bus_halted;
                end
                CMD_PROG_LD:
                begin
                    if (address < PROG_LIMIT)
                    begin
                        prog_we = 1'b1;
                        // boot patch on the program image
                        if (address == PATCH_OFFSET && data == PATCH_FROM)
                        begin
                            prog_wdata = PATCH_TO;
                        end
                    end
                end
                CMD_DICT_LD:
                begin
                    dict_we = address < DICT_LIMIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
            bank_reg     <= '0;
            pointer_reg  <= '0;
            glyph_reg    <= '0;
            halted_reg   <= 1'b0;
            done_reg     <= 1'b0;
            chg_reg      <= 1'b0;
            lvl_reg      <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_reg <= clr_reg + 19'd1;
                if (clr_reg == CLR_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            bank_reg    <= bank_next;
            pointer_reg <= pointer_next;
            glyph_reg   <= glyph_next;
            halted_reg  <= halted_next;
            done_reg    <= accept;
            chg_reg     <= chg_next;
            lvl_reg     <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    kccb_ram #(.DEPTH(RAM_DEPTH), .DATA_W(8)) u_shared_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    kccb_ram #(.DEPTH(PROG_DEPTH), .DATA_W(8)) u_prog_rom (
        .clk   (clk),
        .we    (prog_we),
        .addr  (prog_addr),
        .wdata (prog_wdata),
        .rdata (prog_q)
    );

    kccb_ram #(.DEPTH(DICT_DEPTH), .DATA_W(8)) u_dict_rom (
        .clk   (clk),
        .we    (dict_we),
        .addr  (dict_addr),
        .wdata (dict_wdata),
        .rdata (dict_q)
    );

    always_comb
    begin
        case (sel_reg)
            RSEL_STATUS: read_data = HALTED_CODE;
            RSEL_RAM:    read_data = ram_q;
            RSEL_DICT:   read_data = dict_q;
            RSEL_PROG:   read_data = prog_q;
            RSEL_BANK:   read_data = {2'b00, bank_reg};
            default:     read_data = IDLE_BYTE;
        endcase
    end

    assign done            = done_reg;
    assign halt_req_change = chg_reg;
    assign halt_req_level  = lvl_reg;

endmodule

>>> rtl/core/kccb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kccb_ram
// Single-port synchronous byte memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module kccb_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
